@@ src/hgb_pkg.sv @@
// Shared constants, types and codes of the heightmap gradient bitangent block.
package hgb_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT    = 4096;
	localparam int DIM_W         = 13;
	localparam int ROW_W         = 12;
	localparam int HEIGHT_W      = 16;
	localparam int DIR_W         = 16;
	localparam int FRAC_BITS     = 14;
	localparam int ONE_Q14       = 16384;
	localparam int QUEUE_DEPTH   = 4;
	localparam int CFG_AW        = 3;
	localparam int APB_DW        = 32;
	localparam logic [DIM_W-1:0] DIM_RESET = 13'd256;

	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic has_l;
		logic has_r;
		logic has_u;
		logic has_d;
		logic eof;
	} nbr_flags_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_DIFF,
		ST_SUM,
		ST_SQ,
		ST_T2,
		ST_MLO,
		ST_MHI,
		ST_CMP,
		ST_DONE
	} back_state_t;

endpackage

@@ src/hgb_front.sv @@
// Front part: takes words, keeps the sample ring and decides which pixel is due.
module hgb_front import hgb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF,
	parameter int RING_AW   = 14,
	parameter int WCW       = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                restart,
	input  logic [WCW-1:0]      eff_w,
	input  logic [DIM_W-1:0]    eff_h,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [HEIGHT_W-1:0] height,
	input  logic                flush,
	input  logic                q_full,
	output logic                push,
	output logic [RING_AW-1:0]  push_addr,
	output nbr_flags_t          push_flags,
	input  logic                rd_en,
	input  logic [RING_AW-1:0]  rd_addr,
	output logic [HEIGHT_W-1:0] rd_data
);

	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int PW         = $clog2(MAX_WIDTH + 2);
	localparam int RING_DEPTH = 2 ** RING_AW;

	logic [HEIGHT_W-1:0] ring_mem [RING_DEPTH];
	logic [HEIGHT_W-1:0] rd_data_q;
	logic [RING_AW-1:0]  wp_q;
	logic [PW-1:0]       pend_q;
	logic [CW-1:0]       ecol_q;
	logic [ROW_W-1:0]    erow_q;

	logic             accept, pix, emit;
	logic [WCW-1:0]   col_inc;
	logic [DIM_W-1:0] row_inc;
	logic [PW-1:0]    need;
	logic             has_r, has_d;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pix      = accept && !flush;

	assign col_inc = WCW'(ecol_q) + WCW'(1);
	assign row_inc = DIM_W'(erow_q) + DIM_W'(1);
	assign has_r   = col_inc < eff_w;
	assign has_d   = row_inc < eff_h;
	assign need    = has_d ? PW'(eff_w) : (has_r ? PW'(1) : '0);

	always_comb begin
		if (pix) begin
			emit = pend_q > PW'(eff_w);
		end else begin
			emit = accept && (pend_q > need);
		end
	end

	assign push             = emit;
	assign push_addr        = wp_q - RING_AW'(pend_q);
	assign push_flags.has_l = ecol_q != '0;
	assign push_flags.has_r = has_r;
	assign push_flags.has_u = erow_q != '0;
	assign push_flags.has_d = has_d;
	assign push_flags.eof   = !has_r && !has_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			pend_q <= '0;
			ecol_q <= '0;
			erow_q <= '0;
		end else begin
			if (pix) begin
				wp_q <= wp_q + RING_AW'(1);
			end
			if (restart) begin
				pend_q <= '0;
				ecol_q <= '0;
				erow_q <= '0;
			end else begin
				if (pix && !emit) begin
					pend_q <= pend_q + PW'(1);
				end else if (!pix && emit) begin
					pend_q <= pend_q - PW'(1);
				end
				if (emit) begin
					if (has_r) begin
						ecol_q <= CW'(col_inc);
					end else begin
						ecol_q <= '0;
						erow_q <= has_d ? ROW_W'(row_inc) : '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix) begin
			ring_mem[wp_q] <= height;
		end
		if (rd_en) begin
			rd_data_q <= ring_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/hgb_queue.sv @@
// Short job queue between the front and back parts.
module hgb_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] din,
	input  logic              pop,
	output logic [DATA_W-1:0] dout,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ src/hgb_back.sv @@
// Back part: fetches the four neighbors, forms the differences and normalizes them.
module hgb_back import hgb_pkg::*; #(
	parameter int RING_AW = 14,
	parameter int WCW     = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [WCW-1:0]      eff_w,
	input  logic                job_valid,
	input  logic [RING_AW-1:0]  job_addr,
	input  nbr_flags_t          job_flags,
	output logic                pop,
	output logic                rd_en,
	output logic [RING_AW-1:0]  rd_addr,
	input  logic [HEIGHT_W-1:0] rd_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [DIR_W-1:0]    dir_x,
	output logic [DIR_W-1:0]    dir_y,
	output logic                flat,
	output logic                eof
);

	localparam int GW   = HEIGHT_W + 1;
	localparam int SW   = 2 * HEIGHT_W + 1;
	localparam int LW   = FRAC_BITS + 1;
	localparam int TW   = LW + 1;
	localparam int SLW  = 17;
	localparam int PRW  = 2 * TW + SW + 1;

	back_state_t state_q, state_d;

	logic [RING_AW-1:0]   p_q;
	nbr_flags_t           flags_q;
	logic [1:0]           rcnt_q, ridx_s1;
	logic                 rvld_s1;
	logic [HEIGHT_W-1:0]  sl_q, sr_q, su_q, sd_q;
	logic signed [GW-1:0] gx_q, gy_q;
	logic [SW-1:0]        s_q;
	logic                 comp_q;
	logic [PRW-1:0]       rhs_q;
	logic [LW-1:0]        lo_q;
	logic [3:0]           bit_q;
	logic [2*TW-1:0]      t2_q;
	logic [2*TW+SLW-1:0]  plo_q;
	logic [2*TW+SW-SLW-1:0] phi_q;
	logic [DIR_W-1:0]     dirx_q, diry_q, resx_q, resy_q;
	logic                 flat_q, eof_q, out_valid_q;

	logic [RING_AW-1:0]   w_ring;
	logic signed [GW-1:0] cval;
	logic [HEIGHT_W-1:0]  mag;
	logic [LW-1:0]        cand;
	logic [TW-1:0]        tval;
	logic [PRW-1:0]       prod;
	logic [LW-1:0]        lo_nx;
	logic [DIR_W-1:0]     res;
	logic                 out_load;

	assign w_ring = RING_AW'(eff_w);
	assign cval   = comp_q ? gx_q : -gy_q;
	assign mag    = HEIGHT_W'(cval < 0 ? -cval : cval);
	assign cand   = lo_q | (LW'(1) << bit_q);
	assign tval   = {cand, 1'b0} - TW'(1);
	assign prod   = (PRW'(phi_q) << SLW) + PRW'(plo_q);
	assign lo_nx  = (prod <= rhs_q) ? cand : lo_q;
	assign res    = (cval < 0) ? -DIR_W'(lo_nx) : DIR_W'(lo_nx);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (job_valid) state_d = ST_READ;
			ST_READ: if (rcnt_q == 2'd3) state_d = ST_WAIT;
			ST_WAIT: state_d = ST_DIFF;
			ST_DIFF: state_d = ST_SUM;
			ST_SUM: begin
				if ((gx_q == '0) && (gy_q == '0)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_SQ:  state_d = ST_T2;
			ST_T2:  state_d = ST_MLO;
			ST_MLO: state_d = ST_MHI;
			ST_MHI: state_d = ST_CMP;
			ST_CMP: begin
				if (bit_q != '0) begin
					state_d = ST_T2;
				end else if (!comp_q) begin
					state_d = ST_SQ;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop     = (state_q == ST_IDLE) && job_valid;
		rd_en   = state_q == ST_READ;
		rd_addr = p_q;
		unique case (rcnt_q)
			2'd0: rd_addr = flags_q.has_l ? p_q - RING_AW'(1) : p_q;
			2'd1: rd_addr = flags_q.has_r ? p_q + RING_AW'(1) : p_q;
			2'd2: rd_addr = flags_q.has_u ? p_q - w_ring : p_q;
			2'd3: rd_addr = flags_q.has_d ? p_q + w_ring : p_q;
			default: rd_addr = p_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rcnt_q      <= '0;
			rvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rvld_s1 <= rd_en;
			if (state_q == ST_IDLE) begin
				rcnt_q <= '0;
			end else if (state_q == ST_READ) begin
				rcnt_q <= rcnt_q + 2'd1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= rcnt_q;
		if (pop) begin
			p_q     <= job_addr;
			flags_q <= job_flags;
		end
		if (rvld_s1) begin
			unique case (ridx_s1)
				2'd0: sl_q <= rd_data;
				2'd1: sr_q <= rd_data;
				2'd2: su_q <= rd_data;
				2'd3: sd_q <= rd_data;
				default: sl_q <= rd_data;
			endcase
		end
		unique case (state_q)
			ST_DIFF: begin
				gx_q   <= $signed({1'b0, sr_q}) - $signed({1'b0, sl_q});
				gy_q   <= $signed({1'b0, sd_q}) - $signed({1'b0, su_q});
				comp_q <= 1'b0;
			end
			ST_SUM: begin
				s_q <= unsigned'(SW'(gx_q) * SW'(gx_q)) + unsigned'(SW'(gy_q) * SW'(gy_q));
			end
			ST_SQ: begin
				rhs_q <= PRW'(32'(mag) * 32'(mag)) << (2 * FRAC_BITS + 2);
				lo_q  <= '0;
				bit_q <= 4'(FRAC_BITS);
			end
			ST_T2:  t2_q  <= tval * tval;
			ST_MLO: plo_q <= t2_q * s_q[SLW-1:0];
			ST_MHI: phi_q <= t2_q * s_q[SW-1:SLW];
			ST_CMP: begin
				lo_q <= lo_nx;
				if (bit_q != '0) begin
					bit_q <= bit_q - 4'd1;
				end else if (!comp_q) begin
					resx_q <= res;
					comp_q <= 1'b1;
				end else begin
					resy_q <= res;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			flat_q <= (gx_q == '0) && (gy_q == '0);
			eof_q  <= flags_q.eof;
			if ((gx_q == '0) && (gy_q == '0)) begin
				dirx_q <= '0;
				diry_q <= '0;
			end else begin
				dirx_q <= resx_q;
				diry_q <= resy_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign dir_x     = dirx_q;
	assign dir_y     = diry_q;
	assign flat      = flat_q;
	assign eof       = eof_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |=> (lo_q <= LW'(ONE_Q14)))
		else $error("Normalized magnitude exceeds one.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ) |-> (s_q != '0))
		else $error("Search started on a zero gradient.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("Result overwritten before it was taken.");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q == ST_READ) && (rcnt_q == 2'd0))
		else $error("Job popped without starting its fetch.");

endmodule

@@ src/heightmap_gradient_bitangent_top.sv @@
// Top level of the heightmap gradient bitangent block with its register port.
//
// Channel  Dir  Payload
// s_axis   in   tdata[15:0] height, tuser[0] flush
// m_axis   out  tdata[15:0] dir_x, tdata[31:16] dir_y, tuser[0] flat, tlast end_of_frame
// apb      in   frame_width at 0x0, frame_height at 0x4
//
// The front takes one word per cycle while its four-entry job queue has room.
// Each result occupies the back through taking the job, the four sample reads, forming
// the differences and their sum, two searches of one setup state plus fifteen steps
// through T2, MLO, MHI and CMP, and loading the output; a flat pixel skips the searches.
// A result held at the output stalls the back, and a full queue stalls the input.
// A result appears W+1 pixel words after its pixel; flush words drain the rest.
// Reset sets both dimensions to 256 and clears the counters; the sample memory is not cleared.
// Any register write restarts the stream and drops pending pixels.
module heightmap_gradient_bitangent_top import hgb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,   // height
	input  logic [0:0]        s_axis_tuser,   // flush
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [31:0]       m_axis_tdata,   // dir_x, dir_y
	output logic [0:0]        m_axis_tuser,   // flat
	output logic              m_axis_tlast,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int WCW     = $clog2(MAX_WIDTH + 1);
	localparam int RING_AW = $clog2(2 * MAX_WIDTH + QUEUE_DEPTH + 4);
	localparam int JOB_W   = RING_AW + $bits(nbr_flags_t);

	logic [DIM_W-1:0]   width_q, height_q;
	logic               cfg_wr;
	cfg_reg_t           cfg_sel;
	logic [WCW-1:0]     eff_w;
	logic [DIM_W-1:0]   eff_h;

	logic               q_full, q_empty, push, pop;
	logic [RING_AW-1:0] push_addr, job_addr, rd_addr;
	nbr_flags_t         push_flags, job_flags;
	logic [JOB_W-1:0]   job_word;
	logic               rd_en;
	logic [HEIGHT_W-1:0] rd_data;
	logic [DIR_W-1:0]   dir_x, dir_y;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = cfg_reg_t'(paddr[2]);
	assign prdata  = (cfg_sel == REG_FRAME_HEIGHT) ? APB_DW'(height_q) : APB_DW'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_FRAME_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: width_q <= width_q;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			eff_w = WCW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = WCW'(MAX_WIDTH);
		end else begin
			eff_w = WCW'(width_q);
		end
		if (height_q == '0) begin
			eff_h = DIM_W'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			eff_h = DIM_W'(MAX_HEIGHT);
		end else begin
			eff_h = height_q;
		end
	end

	hgb_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.RING_AW  (RING_AW),
		.WCW      (WCW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (cfg_wr),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.height    (s_axis_tdata),
		.flush     (s_axis_tuser[0]),
		.q_full    (q_full),
		.push      (push),
		.push_addr (push_addr),
		.push_flags(push_flags),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	hgb_queue #(
		.DATA_W(JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   ({push_flags, push_addr}),
		.pop   (pop),
		.dout  (job_word),
		.full  (q_full),
		.empty (q_empty)
	);

	assign job_addr  = job_word[RING_AW-1:0];
	assign job_flags = nbr_flags_t'(job_word[JOB_W-1:RING_AW]);

	hgb_back #(
		.RING_AW(RING_AW),
		.WCW    (WCW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff_w    (eff_w),
		.job_valid(!q_empty),
		.job_addr (job_addr),
		.job_flags(job_flags),
		.pop      (pop),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.flat     (m_axis_tuser[0]),
		.eof      (m_axis_tlast)
	);

	assign m_axis_tdata = {dir_y, dir_x};

endmodule

@@ tb/sv/heightmap_gradient_bitangent_top_test.sv @@
// Self-checking testbench for the heightmap gradient bitangent top level.
`timescale 1ns / 100ps

module heightmap_gradient_bitangent_top_test;
	import hgb_pkg::*;

	localparam int LINE_LEN = 2 * MAX_WIDTH_DEF + 4;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic [15:0] height;
		logic        flush;
	} pixel_word_t;

	typedef struct {
		logic [15:0] dir_x;
		logic [15:0] dir_y;
		logic        flat;
		logic        eof;
	} bitangent_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata = '0;   // height
	logic [0:0]        s_axis_tuser = '0;   // flush
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [31:0]       m_axis_tdata;        // dir_x, dir_y
	logic [0:0]        m_axis_tuser;        // flat
	logic              m_axis_tlast;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	heightmap_gradient_bitangent_top u_top (.*);

	always #5 clk = ~clk;

	pixel_word_t pixel_feed[$];
	bitangent_t  expected_dirs[$];
	pixel_word_t next_word;
	int          gap_pct = 0;
	int          stall_pct = 0;
	int          errors = 0;
	int          quiet_cycles = 0;

	// Predictor state.
	logic [15:0] delay_line[LINE_LEN];
	int unsigned wr_pos, pend_cnt, out_col, out_row, frame_w, frame_h;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
		if (v < 1) return 1;
		return (v > hi) ? hi : v;
	endfunction

	function automatic longint sample_ago(int unsigned k);
		return longint'(delay_line[(wr_pos + LINE_LEN - 1 - (k % LINE_LEN)) % LINE_LEN]);
	endfunction

	function automatic logic [15:0] to_q14(longint c, longint unsigned s);
		longint unsigned m, a, lim, t;
		int unsigned lo, hi, mid;
		m = (c < 0) ? longint'(-c) : longint'(c);
		a = m * ONE_Q14;
		lim = 4 * a * a;
		lo = 0;
		hi = ONE_Q14;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			t = 2 * longint'(mid) - 1;
			if (t * t * s <= lim) lo = mid; else hi = mid - 1;
		end
		return (c < 0) ? 16'(-int'(lo)) : 16'(lo);
	endfunction

	function automatic void emit_bitangent(int unsigned w, int unsigned h);
		int unsigned d, kl, kr, ku, kd;
		longint gx, gy;
		longint unsigned s;
		bitangent_t r;
		d = pend_cnt - 1;
		kl = (out_col > 0) ? d + 1 : d;
		kr = (out_col + 1 < w) ? d - 1 : d;
		ku = (out_row > 0) ? d + w : d;
		kd = (out_row + 1 < h) ? d - w : d;
		gx = sample_ago(kr) - sample_ago(kl);
		gy = sample_ago(kd) - sample_ago(ku);
		s = gx * gx + gy * gy;
		r.flat = (s == 0);
		r.dir_x = (s == 0) ? '0 : to_q14(-gy, s);
		r.dir_y = (s == 0) ? '0 : to_q14(gx, s);
		r.eof = (out_col + 1 == w) && (out_row + 1 == h);
		expected_dirs.insert(expected_dirs.size(), r);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h) out_row = 0;
		end
		pend_cnt--;
	endfunction

	function automatic void predict_word(logic [15:0] height, logic flush);
		int unsigned w, h, need;
		w = clamp_dim(frame_w, MAX_WIDTH_DEF);
		h = clamp_dim(frame_h, MAX_HEIGHT);
		if (!flush) begin
			delay_line[wr_pos] = height;
			wr_pos = (wr_pos + 1) % LINE_LEN;
			pend_cnt++;
			if (pend_cnt > w + 1) emit_bitangent(w, h);
		end else if (pend_cnt > 0) begin
			need = (out_row + 1 < h) ? w : ((out_col + 1 < w) ? 1 : 0);
			if (pend_cnt - 1 >= need) emit_bitangent(w, h);
		end
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pixel_feed.size() > 0 && $urandom_range(99) >= gap_pct) begin
					next_word = pixel_feed.pop_front();
					s_axis_tdata <= next_word.height;
					s_axis_tuser <= next_word.flush;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_dirs.size() == 0) begin
					report_mismatch("unexpected word", m_axis_tdata[15:0], 16'h0000);
				end else begin
					bitangent_t e;
					e = expected_dirs.pop_front();
					if (m_axis_tdata[15:0] !== e.dir_x)
						report_mismatch("dir_x", m_axis_tdata[15:0], e.dir_x);
					if (m_axis_tdata[31:16] !== e.dir_y)
						report_mismatch("dir_y", m_axis_tdata[31:16], e.dir_y);
					if (m_axis_tuser[0] !== e.flat)
						report_mismatch("flat", 16'(m_axis_tuser[0]), 16'(e.flat));
					if (m_axis_tlast !== e.eof)
						report_mismatch("end_of_frame", 16'(m_axis_tlast), 16'(e.eof));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_word(s_axis_tdata, s_axis_tuser[0]);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL heightmap_gradient_bitangent_top");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (pixel_feed.size() > 0 || s_axis_tvalid || expected_dirs.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [12:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= CFG_AW'(4 * int'(idx));
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_FRAME_WIDTH) frame_w = value; else frame_h = value;
		pend_cnt = 0;
		out_col = 0;
		out_row = 0;
	endtask

	task automatic push_word(logic [15:0] height, logic flush);
		pixel_word_t p;
		p.height = height;
		p.flush = flush;
		pixel_feed.insert(pixel_feed.size(), p);
	endtask

	task automatic run_phase(int idx, logic [12:0] w, logic [12:0] h, int npix, int mode);
		int unsigned weff, ndrain;
		logic [15:0] v;
		wait_drained();
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		gap_pct = (idx % 4 == 1) ? 75 : (idx % 4 == 3) ? 35 : 0;
		stall_pct = (idx % 4 == 2) ? 75 : (idx % 4 == 3) ? 35 : 0;
		weff = clamp_dim(w, MAX_WIDTH_DEF);
		for (int i = 0; i < npix; i++) begin
			if ($urandom_range(99) < 5) push_word(16'($urandom), 1'b1);
			case (mode)
				0: v = 16'($urandom);
				1: v = 16'($urandom_range(2));
				default: v = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			endcase
			push_word(v, 1'b0);
		end
		ndrain = (weff <= 64) ? weff + 1 : 8;
		repeat (ndrain) push_word(16'($urandom), 1'b1);
	endtask

	initial begin
		frame_w = DIM_RESET;
		frame_h = DIM_RESET;
		wr_pos = 0;
		pend_cnt = 0;
		out_col = 0;
		out_row = 0;
		foreach (delay_line[i]) delay_line[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: a flush with nothing pending, then a 3x3 frame of extreme samples.
		write_reg(REG_FRAME_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		push_word(16'hFFFF, 1'b1);
		push_word(16'h0000, 1'b0);
		push_word(16'hFFFF, 1'b0);
		push_word(16'h0000, 1'b0);
		push_word(16'h0000, 1'b0);
		push_word(16'h0000, 1'b0);
		push_word(16'h0000, 1'b0);
		push_word(16'hFFFF, 1'b0);
		push_word(16'hFFFF, 1'b0);
		push_word(16'h0000, 1'b0);
		repeat (5) push_word(16'h0000, 1'b1);

		run_phase(0, 13'd1, 13'd1, 40, 0);
		run_phase(1, 13'd2, 13'd2, 60, 1);
		run_phase(2, 13'd3, 13'd5, 150, 0);
		run_phase(3, 13'd8, 13'd4, 200, 2);
		run_phase(4, 13'd16, 13'd3, 300, 0);
		run_phase(5, 13'd1, 13'd7, 70, 1);
		run_phase(6, 13'd7, 13'd1, 70, 0);
		run_phase(7, 13'd0, 13'd0, 20, 0);
		run_phase(8, 13'h1FFF, 13'd2, 30, 0);
		run_phase(9, 13'd40, 13'h1FFF, 250, 1);
		run_phase(10, 13'd5, 13'd4, 300, 0);
		run_phase(11, 13'd4, 13'd6, 150, 2);
		wait_drained();

		if (errors == 0)
			$display("PASS heightmap_gradient_bitangent_top");
		else
			$display("FAIL heightmap_gradient_bitangent_top");
		$finish;
	end

endmodule
